### design/dot_bracket_pair_matcher_unit_macros.svh
// Assertion macros for the dot-bracket pair matcher.
// Expects clk and arst_n in the scope of each use.
`ifndef DOT_BRACKET_PAIR_MATCHER_UNIT_MACROS_SVH
`define DOT_BRACKET_PAIR_MATCHER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define DBPM_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define DBPM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DBPM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DBPM_ASSERT(lbl, cond, msg)
`define DBPM_ASSERT_IMP(lbl, ante, cons, msg)
`define DBPM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### design/dbpm_pkg.sv
// Shared constants for the dot-bracket pair matcher: symbol codes,
// status codes, field widths and parameter defaults. No dependencies.
`default_nettype none
package dbpm_pkg;

	localparam int unsigned MAX_LENGTH_DEF = 1024;

	localparam int unsigned POS_W = 10;
	localparam int unsigned SEP_W = 11;
	localparam logic [SEP_W-1:0] SEP_RESET = 11'd1024;

	localparam logic [1:0] SYM_OPEN  = 2'd1;
	localparam logic [1:0] SYM_CLOSE = 2'd2;

	typedef enum logic [1:0] {
		ST_OK            = 2'd0,
		ST_CLOSE_NO_OPEN = 2'd1,
		ST_UNCLOSED      = 2'd2,
		ST_OVERFLOW      = 2'd3
	} status_t;

endpackage
`default_nettype wire

### design/dot_bracket_pair_matcher_unit.sv
// Dot-bracket pair matcher: numbers structure symbols, matches brackets
// through a stack memory and streams out pairs and end-of-structure status.
// Depends on dbpm_pkg and dot_bracket_pair_matcher_unit_macros.svh.
// An accepted beat's result, if any, is registered in s1, then in the output register, and shown on m_*.
// Throughput: one beat per cycle while the output is not stalled; each beat makes at most one stack access.
// Stack read data is registered into s1 at the accept edge, then moves to the output reg.
// Reset: async, clears counter, depth, separator flag and pipeline valids, and
// sets the separator register to SEP_RESET; stack memory is not cleared.
`default_nettype none
`include "dot_bracket_pair_matcher_unit_macros.svh"

module dot_bracket_pair_matcher_unit
	import dbpm_pkg::*;
#(
	parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [SEP_W-1:0]  cfg_wr_data,   // separator_position
	input  wire logic              s_tvalid,
	output      logic              s_tready,
	input  wire logic [7:0]        s_tdata,       // [1:0] symbol, [7:2] zero
	input  wire logic              s_tlast,       // last_symbol
	output      logic              m_tvalid,
	input  wire logic              m_tready,
	// [9:0] open_position, [19:10] close_position, [21:20] status, [23:22] zero
	output      logic [23:0]       m_tdata,
	output      logic              m_tuser,       // pair_found
	output      logic              m_tlast        // end_of_structure
);

	localparam int unsigned AW    = $clog2(MAX_LENGTH);
	localparam int unsigned CW    = $clog2(MAX_LENGTH + 1);
	localparam int unsigned CMP_W = (CW > SEP_W) ? CW : SEP_W;

	logic [SEP_W-1:0] sep_pos_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    depth_q;
	logic             sep_seen_q;

	logic [AW-1:0]    stack_mem [MAX_LENGTH];

	// s1: result waiting on stack read data
	logic             v_s1;
	logic [AW-1:0]    rd_s1;
	logic [AW-1:0]    close_s1;
	logic             pair_s1;
	logic             last_s1;
	status_t          status_s1;

	// output register
	logic             out_v_q;
	logic [AW-1:0]    out_open_q;
	logic [AW-1:0]    out_close_q;
	logic             out_pair_q;
	logic             out_last_q;
	status_t          out_status_q;

	logic             s_acc, adv_s1, out_free;
	logic             sep_hit, len_ovf, body, is_open, is_close;
	logic             push, push_ovf, pop, close_err, emit;
	logic [CW-1:0]    depth_nxt;
	logic [AW-1:0]    top_addr;
	status_t          status_c;

	assign out_free = !out_v_q || m_tready;
	assign adv_s1   = v_s1 && out_free;
	assign s_tready = !v_s1 || out_free;
	assign s_acc    = s_tvalid && s_tready;

	always_comb begin
		sep_hit   = !sep_seen_q && (CMP_W'(cnt_q) == CMP_W'(sep_pos_q));
		len_ovf   = !sep_hit && (cnt_q >= CW'(MAX_LENGTH));
		body      = !sep_hit && !len_ovf;
		is_open   = body && (s_tdata[1:0] == SYM_OPEN);
		is_close  = body && (s_tdata[1:0] == SYM_CLOSE);
		push      = is_open && (depth_q < CW'(MAX_LENGTH));
		push_ovf  = is_open && !push;
		pop       = is_close && (depth_q != '0);
		close_err = is_close && (depth_q == '0);
		depth_nxt = depth_q + CW'(push) - CW'(pop);
		top_addr  = AW'(depth_q - CW'(1));
		emit      = len_ovf || push_ovf || pop || close_err || s_tlast;
		priority if (len_ovf || push_ovf) begin
			status_c = ST_OVERFLOW;
		end else if (close_err) begin
			status_c = ST_CLOSE_NO_OPEN;
		end else if (s_tlast && (depth_nxt != '0)) begin
			status_c = ST_UNCLOSED;
		end else begin
			status_c = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_pos_q <= SEP_RESET;
		end else if (cfg_wr_en) begin
			sep_pos_q <= cfg_wr_data;
		end
	end

	// Structure state moves at the accept edge, so the next beat already
	// sees the updated depth; push and pop never share an edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			depth_q    <= '0;
			sep_seen_q <= 1'b0;
		end else if (s_acc) begin
			if (s_tlast) begin
				cnt_q      <= '0;
				depth_q    <= '0;
				sep_seen_q <= 1'b0;
			end else begin
				cnt_q      <= cnt_q + CW'(body);
				depth_q    <= depth_nxt;
				sep_seen_q <= sep_seen_q || sep_hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && push) begin
			stack_mem[depth_q[AW-1:0]] <= cnt_q[AW-1:0];
		end
		if (s_acc && pop) begin
			rd_s1 <= stack_mem[top_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_acc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && emit) begin
			close_s1  <= cnt_q[AW-1:0];
			pair_s1   <= pop;
			last_s1   <= s_tlast;
			status_s1 <= status_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_open_q   <= pair_s1 ? rd_s1 : '0;
			out_close_q  <= pair_s1 ? close_s1 : '0;
			out_pair_q   <= pair_s1;
			out_last_q   <= last_s1;
			out_status_q <= status_s1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_pair_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {2'b00, out_status_q, POS_W'(out_close_q), POS_W'(out_open_q)};

	`DBPM_ASSERT(a_depth_le_cnt, depth_q <= cnt_q, "stack depth exceeds position count")
	`DBPM_ASSERT_IMP(a_pair_order, out_v_q && out_pair_q, out_open_q < out_close_q,
		"pair open position not below close position")
	`DBPM_ASSERT_IMP(a_noopen_nopair, out_v_q && (out_status_q == ST_CLOSE_NO_OPEN),
		!out_pair_q, "pair reported with close-without-open status")
	`DBPM_ASSERT_NXT(a_last_clears, s_acc && s_tlast,
		(cnt_q == '0) && (depth_q == '0) && !sep_seen_q, "structure state not cleared")
	`DBPM_ASSERT_NXT(a_s1_held, v_s1 && !out_free, v_s1, "stalled result dropped from s1")

endmodule
`default_nettype wire

### sim/testbench.sv
// Self-checking bench for dot_bracket_pair_matcher_unit: directed and random symbol streams,
// an in-bench pair-matching predictor, and a result checker behind random stalls.
// Depends on dbpm_pkg and the unit RTL only.
`timescale 1ns / 100ps

module testbench;
	import dbpm_pkg::*;

	localparam logic [1:0] SYM_DOT = 2'd0;
	localparam logic [1:0] SYM_ODD = 2'd3;   // unused code, behaves as a dot
	localparam int unsigned MAX_LEN = MAX_LENGTH_DEF;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned SETTLE_CYCLES = 4;

	typedef struct {
		logic [1:0] sym;
		logic       last;
	} symbol_beat_t;

	typedef struct {
		logic [POS_W-1:0] open_pos;
		logic [POS_W-1:0] close_pos;
		logic             pair;
		logic             eos;
		status_t          status;
	} pair_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [SEP_W-1:0] cfg_wr_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	dot_bracket_pair_matcher_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	symbol_beat_t symbol_queue[$];
	pair_result_t awaited_results[$];

	// predictor state
	logic [POS_W-1:0] open_stack_model[MAX_LEN];
	int unsigned stack_level;
	int unsigned position;
	logic separator_done;
	logic [SEP_W-1:0] separator_reg;

	int send_idle_pct = 32;
	int recv_idle_pct = 46;
	int unsigned error_count = 0;
	int unsigned beats_sent = 0;
	int unsigned results_seen = 0;
	int unsigned cfg_writes = 0;
	int unsigned structures = 0;
	int unsigned cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic clear_structure_model();
		stack_level = 0;
		position = 0;
		separator_done = 1'b0;
	endtask

	// Work out the result (if any) of one accepted symbol.
	task automatic match_symbol(input logic [1:0] sym, input logic last);
		pair_result_t r;
		bit emit;
		bit err;
		r.open_pos = '0;
		r.close_pos = '0;
		r.pair = 1'b0;
		r.eos = 1'b0;
		r.status = ST_OK;
		emit = 0;
		err = 0;
		if (!separator_done && position == separator_reg) begin
			separator_done = 1'b1;
		end else if (position >= MAX_LEN) begin
			emit = 1;
			err = 1;
			r.status = ST_OVERFLOW;
		end else begin
			if (sym == SYM_OPEN) begin
				if (stack_level < MAX_LEN) begin
					open_stack_model[stack_level] = position[POS_W-1:0];
					stack_level++;
				end else begin
					emit = 1;
					err = 1;
					r.status = ST_OVERFLOW;
				end
			end else if (sym == SYM_CLOSE) begin
				emit = 1;
				if (stack_level > 0) begin
					stack_level--;
					r.open_pos = open_stack_model[stack_level];
					r.close_pos = position[POS_W-1:0];
					r.pair = 1'b1;
				end else begin
					err = 1;
					r.status = ST_CLOSE_NO_OPEN;
				end
			end
			position++;
		end
		if (last) begin
			emit = 1;
			r.eos = 1'b1;
			if (!err)
				r.status = (stack_level != 0) ? ST_UNCLOSED : ST_OK;
			clear_structure_model();
		end
		if (emit)
			awaited_results.insert(awaited_results.size(), r);
	endtask

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		$display("ERROR @%0t: %s expected %0d got %0d", $time, what, want, got);
		error_count++;
	endtask

	task automatic add_symbol(input logic [1:0] sym, input logic last);
		symbol_beat_t b;
		b.sym = sym;
		b.last = last;
		symbol_queue.insert(symbol_queue.size(), b);
	endtask

	// Well-formed structures with random content most of the time, noise otherwise.
	task automatic gen_structure(output int n);
		symbol_beat_t q[$];
		symbol_beat_t b;
		int opens;
		int depth;
		int kind;
		int len;
		depth = 0;
		if ($urandom_range(0, 9) < 8) begin
			opens = $urandom_range(0, 12);
			do begin
				kind = $urandom_range(0, 3);
				if (kind == 0) begin
					b.sym = ($urandom_range(0, 3) == 0) ? SYM_ODD : SYM_DOT;
				end else if (opens > 0 && (depth == 0 || kind == 1)) begin
					b.sym = SYM_OPEN;
					opens--;
					depth++;
				end else if (depth > 0) begin
					b.sym = SYM_CLOSE;
					depth--;
				end else begin
					b.sym = SYM_DOT;
				end
				b.last = 1'b0;
				q.insert(q.size(), b);
			end while (opens > 0 || depth > 0);
		end else begin
			len = $urandom_range(1, 15);
			repeat (len) begin
				b.sym = 2'($urandom_range(0, 3));
				b.last = 1'b0;
				q.insert(q.size(), b);
			end
		end
		q[q.size()-1].last = 1'b1;
		n = q.size();
		symbol_queue = {symbol_queue, q};
		structures++;
	endtask

	// Block is idle once nothing is queued, in flight, or awaited.
	// Sampled mid-cycle so the driver and predictor updates of the edge are settled.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (symbol_queue.size() != 0 || s_tvalid || awaited_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_separator(input logic [SEP_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		separator_reg = value;
		cfg_writes++;
	endtask

	// Source side driver
	always @(posedge clk) begin : drive_symbols
		symbol_beat_t b;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				match_symbol(s_tdata[1:0], s_tlast);
				beats_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (symbol_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					b = symbol_queue.pop_front();
					s_tdata <= {6'd0, b.sym};
					s_tlast <= b.last;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result side monitor
	always @(posedge clk) begin : check_results
		pair_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected result beat, open_position", 0,
						32'(m_tdata[9:0]));
				end else begin
					want = awaited_results.pop_front();
					if (m_tdata[9:0] !== want.open_pos)
						report_mismatch("open_position", 32'(want.open_pos),
							32'(m_tdata[9:0]));
					if (m_tdata[19:10] !== want.close_pos)
						report_mismatch("close_position", 32'(want.close_pos),
							32'(m_tdata[19:10]));
					if (m_tdata[21:20] !== want.status)
						report_mismatch("status", 32'(want.status), 32'(m_tdata[21:20]));
					if (m_tuser !== want.pair)
						report_mismatch("pair_found", 32'(want.pair), 32'(m_tuser));
					if (m_tlast !== want.eos)
						report_mismatch("end_of_structure", 32'(want.eos), 32'(m_tlast));
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d results still awaited",
				cycle_count, awaited_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin : stimulus
		int n;
		int count;
		logic [SEP_W-1:0] sep_choice;
		clear_structure_model();
		separator_reg = SEP_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: pair, close without open on last, unclosed with odd code
		add_symbol(SYM_OPEN, 1'b0);
		add_symbol(SYM_DOT, 1'b0);
		add_symbol(SYM_CLOSE, 1'b1);
		add_symbol(SYM_CLOSE, 1'b1);
		add_symbol(SYM_OPEN, 1'b0);
		add_symbol(SYM_OPEN, 1'b0);
		add_symbol(SYM_ODD, 1'b1);
		add_symbol(SYM_CLOSE, 1'b0);
		add_symbol(SYM_OPEN, 1'b0);
		add_symbol(SYM_CLOSE, 1'b1);
		// leave a structure open across a register write
		add_symbol(SYM_OPEN, 1'b0);
		add_symbol(SYM_OPEN, 1'b0);
		wait_idle();
		write_separator(11'd2);
		add_symbol(SYM_DOT, 1'b0);
		add_symbol(SYM_CLOSE, 1'b0);
		add_symbol(SYM_CLOSE, 1'b1);
		wait_idle();
		// separator at position zero, and a separator that is also last
		write_separator(11'd0);
		add_symbol(SYM_OPEN, 1'b1);
		add_symbol(SYM_CLOSE, 1'b0);
		add_symbol(SYM_CLOSE, 1'b1);
		wait_idle();

		// full-length structure: a stack 1023 deep, then length overflow
		write_separator(SEP_RESET);
		repeat (MAX_LEN - 1) add_symbol(SYM_OPEN, 1'b0);
		add_symbol(SYM_CLOSE, 1'b0);
		add_symbol(SYM_DOT, 1'b0);      // position 1024 taken as separator
		add_symbol(SYM_CLOSE, 1'b0);
		add_symbol(SYM_OPEN, 1'b0);
		add_symbol(SYM_DOT, 1'b1);
		wait_idle();

		// random phases, idling pattern changes every two phases
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: sep_choice = SEP_W'($urandom_range(0, 30));
				1: sep_choice = SEP_RESET;
				2: sep_choice = SEP_W'($urandom_range(0, 1024));
				3: sep_choice = 11'd0;
				4: sep_choice = SEP_W'($urandom_range(1, 12));
				default: sep_choice = SEP_RESET;
			endcase
			if (p < 2) begin
				send_idle_pct = 32;
				recv_idle_pct = 46;
			end else if (p < 4) begin
				send_idle_pct = 46;
				recv_idle_pct = 32;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_separator(sep_choice);
			count = 0;
			while (count < 24) begin
				gen_structure(n);
				count += n;
			end
			wait_idle();
		end

		$display("Sent %0d symbols in %0d random structures plus directed cases;",
			beats_sent, structures);
		$display("checked %0d results across %0d separator settings.",
			results_seen, cfg_writes);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
